// File: src/zfbw_pkg.sv
// Shared types, codes and zoned disk tables for the FAT block walker.
// No dependencies; used by every module of the block.
package zfbw_pkg;

    localparam int LINK_ENTRIES       = 2874;
    localparam int LAST_LOGICAL_BLOCK = 4291;
    localparam int NUM_TYPES          = 6;
    localparam int PHYS_SKEW          = 'h18;
    localparam int SYS_AREA_BYTES     = 'h738C0;
    localparam int LINK_AW            = $clog2(LINK_ENTRIES);

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ACK     = 3'd1;
    localparam logic [2:0] ST_BAD     = 3'd2;
    localparam logic [2:0] ST_ENCODED = 3'd3;
    localparam logic [2:0] ST_CORRUPT = 3'd4;

    localparam logic [1:0] CFG_DISK_TYPE = 2'd0;
    localparam logic [1:0] CFG_RAW_PART  = 2'd1;
    localparam logic [1:0] CFG_IMAGE_SZ  = 2'd2;

    localparam logic [1:0] FN_LOAD  = 2'd0;
    localparam logic [1:0] FN_START = 2'd1;
    localparam logic [1:0] FN_NEXT  = 2'd2;

    typedef enum logic [1:0] {
        K_LOAD  = 2'd0,
        K_START = 2'd1,
        K_NEXT  = 2'd2,
        K_BAD   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind        kind;
        logic [11:0]  idx;
        logic         idx_bad;
        logic [15:0]  val;      // link value or first block
        logic [30:0]  fsize;
        logic         fs_zero;
        logic [2:0]   chk;      // start check ignoring disk type
    } t_item;

    typedef struct packed {
        logic [1:0] count;
    } t_fq_stat;

    typedef struct packed {
        logic busy;
    } t_bk_stat;

    localparam logic [14:0] ZONE_BYTES [9] = '{
        15'h4D08, 15'h47B8, 15'h4510, 15'h3FC0, 15'h3A70,
        15'h3520, 15'h2FD0, 15'h2A80, 15'h2530};

    localparam logic [12:0] END_TBL [NUM_TYPES][16] = '{
        '{13'h0124, 13'h0248, 13'h035A, 13'h047E, 13'h05A2, 13'h06B4, 13'h07C6, 13'h08D8,
          13'h09EA, 13'h0AB6, 13'h0B82, 13'h0C94, 13'h0DA6, 13'h0EB8, 13'h0FCA, 13'h10DC},
        '{13'h0124, 13'h0248, 13'h035A, 13'h046C, 13'h057E, 13'h06A2, 13'h07C6, 13'h08D8,
          13'h09EA, 13'h0AFC, 13'h0BC8, 13'h0C94, 13'h0DA6, 13'h0EB8, 13'h0FCA, 13'h10DC},
        '{13'h0124, 13'h0248, 13'h035A, 13'h046C, 13'h057E, 13'h0690, 13'h07A2, 13'h08C6,
          13'h09EA, 13'h0AFC, 13'h0C0E, 13'h0CDA, 13'h0DA6, 13'h0EB8, 13'h0FCA, 13'h10DC},
        '{13'h0124, 13'h0248, 13'h035A, 13'h046C, 13'h057E, 13'h0690, 13'h07A2, 13'h08B4,
          13'h09C6, 13'h0AEA, 13'h0C0E, 13'h0D20, 13'h0DEC, 13'h0EB8, 13'h0FCA, 13'h10DC},
        '{13'h0124, 13'h0248, 13'h035A, 13'h046C, 13'h057E, 13'h0690, 13'h07A2, 13'h08B4,
          13'h09C6, 13'h0AD8, 13'h0BEA, 13'h0D0E, 13'h0E32, 13'h0EFE, 13'h0FCA, 13'h10DC},
        '{13'h0124, 13'h0248, 13'h035A, 13'h046C, 13'h057E, 13'h0690, 13'h07A2, 13'h086E,
          13'h0980, 13'h0A92, 13'h0BA4, 13'h0CB6, 13'h0DC8, 13'h0EEC, 13'h1010, 13'h10DC}};

    localparam logic [3:0] HEAD_TBL [NUM_TYPES][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd9, 4'd8, 4'd3, 4'd4, 4'd5,
          4'd6, 4'd7, 4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd10, 4'd9, 4'd8, 4'd4,
          4'd5, 4'd6, 4'd7, 4'd15, 4'd14, 4'd13, 4'd12, 4'd11},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd11, 4'd10, 4'd9,
          4'd8, 4'd5, 4'd6, 4'd7, 4'd15, 4'd14, 4'd13, 4'd12},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd12, 4'd11,
          4'd10, 4'd9, 4'd8, 4'd6, 4'd7, 4'd15, 4'd14, 4'd13},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd13,
          4'd12, 4'd11, 4'd10, 4'd9, 4'd8, 4'd7, 4'd15, 4'd14},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8, 4'd15}};

    localparam logic [12:0] RAM_START [NUM_TYPES] = '{
        13'h05A2, 13'h07C6, 13'h09EA, 13'h0C0E, 13'h0E32, 13'h1010};

    function automatic logic [14:0] zone_size(input logic [2:0] t, input logic [3:0] v);
        logic [3:0] z;
        z = HEAD_TBL[t][v];
        if (z >= 4'd8) begin
            z = z - 4'd7;
        end
        return ZONE_BYTES[z];
    endfunction

endpackage

// File: src/zfbw_front.sv
// Front part: accepts input transactions, classifies them and holds them
// in a two-entry queue for the back part. Depends on zfbw_pkg.
module zfbw_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_func,
    input  logic [11:0]       i_link_index,
    input  logic [15:0]       i_link_value,
    input  logic [15:0]       i_attributes,
    input  logic [15:0]       i_first_block,
    input  logic signed [31:0] i_file_size,
    input  logic signed [31:0] i_buffer_size,
    output logic              o_valid,
    output zfbw_pkg::t_item   o_item,
    input  logic              i_take,
    output zfbw_pkg::t_fq_stat o_stat
);
    import zfbw_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_count;
    t_item      w_item;
    logic       w_push, w_pop;

    always_comb begin
        w_item          = '0;
        w_item.idx      = i_link_index;
        w_item.idx_bad  = (i_link_index >= 12'(LINK_ENTRIES));
        w_item.val      = (i_func == FN_LOAD) ? i_link_value : i_first_block;
        w_item.fsize    = i_file_size[30:0];
        w_item.fs_zero  = (i_file_size == 32'sd0);
        case (i_func)
            FN_LOAD:  w_item.kind = K_LOAD;
            FN_START: w_item.kind = K_START;
            FN_NEXT:  w_item.kind = K_NEXT;
            default:  w_item.kind = K_BAD;
        endcase
        if (!i_attributes[14] || i_attributes[15]) begin
            w_item.chk = ST_BAD;
        end else if (i_attributes[10]) begin
            w_item.chk = ST_ENCODED;
        end else if (i_file_size < 0 || i_buffer_size < i_file_size) begin
            w_item.chk = ST_BAD;
        end else begin
            w_item.chk = ST_OK;
        end
    end

    assign full    = (r_count == 2'd2);
    assign w_push  = push && !full;
    assign o_valid = (r_count != 2'd0);
    assign w_pop   = i_take && o_valid;
    assign o_item  = r_q[r_rp];
    assign o_stat.count = r_count;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_count <= r_count + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

// File: src/zfbw_back.sv
// Back part: configuration, link table memory, walk state and the zone
// scan that sizes and places each block. Depends on zfbw_pkg.
module zfbw_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [26:0]       i_cfg_data,
    input  logic              i_valid,
    input  zfbw_pkg::t_item   i_item,
    output logic              o_take,
    output logic              empty,
    input  logic              pop,
    output logic [2:0]        o_status,
    output logic [25:0]       o_byte_offset,
    output logic [14:0]       o_byte_count,
    output logic              o_last,
    output zfbw_pkg::t_bk_stat o_stat
);
    import zfbw_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    t_state       r_state;
    logic [2:0]   r_dt;
    logic         r_raw;
    logic [26:0]  r_img;
    logic [15:0]  r_cur;
    logic [30:0]  r_left;
    logic [11:0]  r_hop;
    logic         r_active;
    logic         r_ovld;
    logic [2:0]   r_st;
    logic [25:0]  r_off;
    logic [14:0]  r_cnt;
    logic         r_last;
    logic [13:0]  r_phys, r_lo;
    logic [3:0]   r_v;
    logic [27:0]  r_prod, r_acc;
    logic [14:0]  r_size;
    logic         r_found;
    logic [15:0]  r_rd;
    logic [15:0]  link_mem [LINK_ENTRIES];

    logic         w_go;
    logic         w_scan;
    logic         w_zero_done;
    logic [13:0]  w_hi, w_prev, w_a, w_b;
    logic [14:0]  w_zs;
    logic [27:0]  w_off;
    logic [28:0]  w_end;
    logic [14:0]  w_n;
    logic [30:0]  w_left;

    assign w_go   = (r_state == S_IDLE) && i_valid && !r_ovld;
    assign o_take = w_go;
    assign empty  = !r_ovld;
    assign o_status      = r_st;
    assign o_byte_offset = r_off;
    assign o_byte_count  = r_cnt;
    assign o_last        = r_last;
    assign o_stat.busy   = (r_state != S_IDLE);

    // continue that goes on to the zone scan
    assign w_scan = (i_item.kind == K_NEXT) && r_active && (r_dt < 3'(NUM_TYPES))
                    && (r_cur != 16'd0) && (r_cur < 16'(LINK_ENTRIES));
    // valid start of an empty file
    assign w_zero_done = (i_item.kind == K_START) && (r_dt < 3'(NUM_TYPES))
                         && (i_item.chk == ST_OK) && i_item.fs_zero;

    always_comb begin
        w_hi   = 14'(END_TBL[r_dt][r_v]);
        w_prev = (r_v == 4'd0) ? 14'd0 : 14'(END_TBL[r_dt][r_v - 4'd1]);
        w_a    = (w_prev < r_lo) ? r_lo : w_prev;
        w_b    = (w_hi < r_phys) ? w_hi : r_phys;
        w_zs   = zone_size(r_dt, r_v);
        w_off  = r_raw ? r_acc : r_acc + 28'(SYS_AREA_BYTES);
        w_end  = 29'(w_off) + 29'(r_size);
        w_n    = (31'(r_size) < r_left) ? r_size : r_left[14:0];
        w_left = r_left - 31'(w_n);
    end

    // Link table: one write port, registered read of the current block.
    always_ff @(posedge i_clk) begin
        if (w_go && i_item.kind == K_LOAD && !i_item.idx_bad) begin
            link_mem[i_item.idx[LINK_AW-1:0]] <= i_item.val;
        end
        r_rd <= link_mem[r_cur[LINK_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN) begin
            r_prod <= (w_b > w_a) ? 28'(w_b - w_a) * 28'(w_zs) : 28'd0;
        end else begin
            r_prod <= 28'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dt     <= 3'd0;
            r_raw    <= 1'b0;
            r_img    <= 27'd64931840;
            r_cur    <= 16'd0;
            r_left   <= 31'd0;
            r_hop    <= 12'd0;
            r_active <= 1'b0;
            r_ovld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DISK_TYPE: r_dt  <= i_cfg_data[2:0];
                    CFG_RAW_PART:  r_raw <= i_cfg_data[0];
                    CFG_IMAGE_SZ:  r_img <= i_cfg_data;
                    default: ;
                endcase
            end
            if (pop && r_ovld) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_go) begin
                        r_ovld <= !w_scan;
                        r_off  <= 26'd0;
                        r_cnt  <= 15'd0;
                        r_last <= w_zero_done;
                        case (i_item.kind)
                            K_LOAD: r_st <= i_item.idx_bad ? ST_BAD : ST_ACK;
                            K_START: begin
                                if (r_dt >= 3'(NUM_TYPES)) begin
                                    r_st     <= ST_BAD;
                                    r_active <= 1'b0;
                                end else if (i_item.chk != ST_OK) begin
                                    r_st     <= i_item.chk;
                                    r_active <= 1'b0;
                                end else begin
                                    r_st     <= ST_ACK;
                                    r_hop    <= 12'd0;
                                    r_cur    <= i_item.val;
                                    r_left   <= i_item.fsize;
                                    r_active <= !i_item.fs_zero;
                                end
                            end
                            K_NEXT: begin
                                if (!r_active || r_dt >= 3'(NUM_TYPES)) begin
                                    r_st     <= ST_BAD;
                                    r_active <= 1'b0;
                                end else if (r_cur == 16'd0
                                        || r_cur >= 16'(LINK_ENTRIES)) begin
                                    r_st     <= ST_CORRUPT;
                                    r_active <= 1'b0;
                                end else begin
                                    // Hold the result until the zone scan is done.
                                    r_phys   <= 14'(RAM_START[r_dt]) + 14'(r_cur[11:0]);
                                    r_lo     <= r_raw ? 14'(RAM_START[r_dt])
                                                      : 14'(PHYS_SKEW);
                                    r_v      <= 4'd0;
                                    r_acc    <= 28'd0;
                                    r_found  <= 1'b0;
                                    r_size   <= 15'd0;
                                    r_state  <= S_SCAN;
                                end
                            end
                            default: r_st <= ST_BAD;
                        endcase
                    end
                end
                S_SCAN: begin
                    r_acc <= r_acc + r_prod;
                    if (!r_found && r_phys < w_hi) begin
                        r_found <= 1'b1;
                        r_size  <= w_zs;
                    end
                    r_v <= r_v + 4'd1;
                    if (r_v == 4'd15) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_acc   <= r_acc + r_prod;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_state <= S_IDLE;
                    r_ovld  <= 1'b1;
                    if (!r_found || w_end > 29'(r_img)
                            || (r_phys - 14'(PHYS_SKEW)) > 14'(LAST_LOGICAL_BLOCK)) begin
                        r_st     <= ST_CORRUPT;
                        r_active <= 1'b0;
                    end else begin
                        r_st   <= ST_OK;
                        r_off  <= w_off[25:0];
                        r_cnt  <= w_n;
                        r_left <= w_left;
                        if (w_left == 31'd0) begin
                            r_last   <= 1'b1;
                            r_active <= 1'b0;
                        end else if (r_hop >= 12'(LINK_ENTRIES)) begin
                            r_cur <= 16'd0;
                        end else begin
                            r_hop <= r_hop + 12'd1;
                            r_cur <= r_rd;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: src/zoned_fat_block_walker_unit.sv
// Top level of the zoned FAT block walker: front queue plus back executor.
// Load, start and rejected items are answered from the idle state; a block continue
// first runs the 16-step zone scan with one multiply each, then a drain and a final
// state. The back part takes one item at a time, and a new one only once the previous
// result has been popped; the front queue holds two.
// Reset (synchronous, active low) clears queue, walk state and configuration;
// the link table is not cleared.
module zoned_fat_block_walker_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [26:0]        i_cfg_data,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_func,
    input  logic [11:0]        i_link_index,
    input  logic [15:0]        i_link_value,
    input  logic [15:0]        i_attributes,
    input  logic [15:0]        i_first_block,
    input  logic signed [31:0] i_file_size,
    input  logic signed [31:0] i_buffer_size,
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         o_status,
    output logic [25:0]        o_byte_offset,
    output logic [14:0]        o_byte_count,
    output logic               o_last
);
    import zfbw_pkg::*;

    logic     w_valid, w_take;
    t_item    w_item;
    t_fq_stat w_fq;
    t_bk_stat w_bk;

    zfbw_front u_front (
        .i_clk, .i_rst_n, .push, .full, .i_func, .i_link_index, .i_link_value,
        .i_attributes, .i_first_block, .i_file_size, .i_buffer_size,
        .o_valid(w_valid), .o_item(w_item), .i_take(w_take), .o_stat(w_fq)
    );

    zfbw_back u_back (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid(w_valid), .i_item(w_item), .o_take(w_take),
        .empty, .pop, .o_status, .o_byte_offset, .o_byte_count, .o_last,
        .o_stat(w_bk)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fq.count != 2'd3)
        else $error("front queue count out of range");

    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bk.busy |-> empty)
        else $error("result shown while a block is still being computed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");
endmodule
